// ===== design/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// Address learning table package
// Shared types and constants for the station address learning table.
// ----------------------------------------------------------------------------
package alt_pkg;

   localparam int ADDR_W     = 48;
   localparam int STRENGTH_W = 8;
   localparam int SWEEP_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 7;

   localparam int GROUP_BIT  = 40;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED       = 3'd0,
      ST_INSERTED      = 3'd1,
      ST_FULL          = 3'd2,
      ST_BAD_ADDRESS   = 3'd3,
      ST_BAD_SWEEP     = 3'd4,
      ST_INVALID_STATE = 3'd5
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_SCAN   = 6'b000100,
      S_UPDATE = 6'b001000,
      S_MISS   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic signed [STRENGTH_W-1:0] best_strength;
      logic [SWEEP_W-1:0]           first_sweep;
      logic [SWEEP_W-1:0]           latest_sweep;
      logic [COUNT_W-1:0]           seen_count;
   } record_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
   } result_type;

endpackage

// ===== design/address_learning_table.sv =====
// ----------------------------------------------------------------------------
// Address learning table
// Learns station addresses with best strength, sweep range and sighting count.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is one sighting of a station: a 48-bit address,
// a signed strength and a sweep number. Each item yields exactly one item on
// the rsp_ channel with a status code and the slot that was touched, or
// TABLE_ENTRIES when no slot was touched.
// Both channels use a valid and ready handshake. The block works on one item
// at a time: req_ready is high only while the engine is idle.
// A rejected item goes from the check state straight to the finish state. A
// miss scans the filled slots, then passes the miss and finish states, and a
// hit in slot i scans slots 0 to i, then the update and finish states. The
// search reads one key per cycle from the key RAM; a hit then takes one
// read-modify-write of the record RAM. req_ready returns high together with
// rsp_valid. The result sits in an output register; the next item is
// accepted while it waits. If the receiver stalls, the following result is
// held in the engine until the output register frees up.
// Reset empties the table and clears the drop counter at once; the RAMs are
// not cleared, since only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module address_learning_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [alt_pkg::ADDR_W-1:0]            req_station_address,
   input  logic signed [alt_pkg::STRENGTH_W-1:0] req_strength,
   input  logic [alt_pkg::SWEEP_W-1:0]           req_sweep_number,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [alt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [alt_pkg::INDEX_W-1:0]           rsp_entry_index
);

   import alt_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       out_free;
   logic       done;
   result_type result;

   assign out_free = !rsp_valid_ff || rsp_ready;

   alt_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_station_address (req_station_address),
      .req_strength        (req_strength),
      .req_sweep_number    (req_sweep_number),
      .out_free            (out_free),
      .done                (done),
      .result              (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_entry_index = rsp_ff.index;

endmodule

// ===== design/alt_ram.sv =====
// ----------------------------------------------------------------------------
// Address learning table RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module alt_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== design/alt_engine.sv =====
// ----------------------------------------------------------------------------
// Address learning table engine
// Linear search over the key RAM, then read-modify-write of the record RAM.
// ----------------------------------------------------------------------------
module alt_engine #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [alt_pkg::ADDR_W-1:0]         req_station_address,
   input  logic signed [alt_pkg::STRENGTH_W-1:0] req_strength,
   input  logic [alt_pkg::SWEEP_W-1:0]        req_sweep_number,
   input  logic                               out_free,
   output logic                               done,
   output alt_pkg::result_type                result
);

   import alt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0]   FULL_FILL  = CNT_W'(TABLE_ENTRIES);
   localparam logic [INDEX_W-1:0] NONE_INDEX = INDEX_W'(TABLE_ENTRIES);
   localparam int REC_W = $bits(record_type);

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [COUNT_W-1:0]           drop_ff, drop_in;
   logic [ADDR_W-1:0]            addr_ff;
   logic signed [STRENGTH_W-1:0] strength_ff;
   logic [SWEEP_W-1:0]           sweep_ff;
   result_type                   result_ff, result_in;

   logic                         key_wr_en;
   logic [ADDR_W-1:0]            key_rd_data;
   logic                         rec_wr_en;
   logic [IDX_W-1:0]             rec_wr_addr;
   record_type                   rec_wr_data;
   logic [REC_W-1:0]             rec_rd_bits;
   record_type                   rec_q;
   logic                         accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rec_q     = record_type'(rec_rd_bits);
   assign result    = result_ff;

   alt_ram #(
      .WIDTH  (ADDR_W),
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_key_ram (
      .clock      (clock),
      .wr_en      (key_wr_en),
      .wr_addr    (fill_ff[IDX_W-1:0]),
      .wr_data    (addr_ff),
      .rd_addr    (cmp_idx_in[IDX_W-1:0]),
      .rd_data_ff (key_rd_data)
   );

   alt_ram #(
      .WIDTH  (REC_W),
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_rec_ram (
      .clock      (clock),
      .wr_en      (rec_wr_en),
      .wr_addr    (rec_wr_addr),
      .wr_data    (rec_wr_data),
      .rd_addr    (cmp_idx_ff[IDX_W-1:0]),
      .rd_data_ff (rec_rd_bits)
   );

   always_comb begin
      state_in    = state_ff;
      cmp_idx_in  = cmp_idx_ff;
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      result_in   = result_ff;
      key_wr_en   = 1'b0;
      rec_wr_en   = 1'b0;
      rec_wr_addr = cmp_idx_ff[IDX_W-1:0];
      rec_wr_data = rec_q;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmp_idx_in = '0;
            if (addr_ff == '0 || addr_ff[GROUP_BIT]) begin
               result_in = '{status: ST_BAD_ADDRESS, index: NONE_INDEX};
               state_in  = S_FINISH;
            end else if (sweep_ff == '0) begin
               result_in = '{status: ST_BAD_SWEEP, index: NONE_INDEX};
               state_in  = S_FINISH;
            end else if (fill_ff == '0) begin
               state_in = S_MISS;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (key_rd_data == addr_ff) begin
               state_in = S_UPDATE;
            end else if (cmp_idx_ff + 1'b1 == fill_ff) begin
               state_in = S_MISS;
            end else begin
               cmp_idx_in = cmp_idx_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            state_in = S_FINISH;
            if (sweep_ff < rec_q.latest_sweep) begin
               result_in = '{status: ST_BAD_SWEEP, index: NONE_INDEX};
            end else if (rec_q.seen_count == '1) begin
               result_in = '{status: ST_INVALID_STATE, index: NONE_INDEX};
            end else begin
               rec_wr_en = 1'b1;
               if (strength_ff > rec_q.best_strength) begin
                  rec_wr_data.best_strength = strength_ff;
               end
               rec_wr_data.latest_sweep = sweep_ff;
               rec_wr_data.seen_count   = rec_q.seen_count + 1'b1;
               result_in = '{status: ST_UPDATED, index: INDEX_W'(cmp_idx_ff)};
            end
         end
         S_MISS: begin
            state_in = S_FINISH;
            if (fill_ff >= FULL_FILL) begin
               if (drop_ff == '1) begin
                  result_in = '{status: ST_INVALID_STATE, index: NONE_INDEX};
               end else begin
                  drop_in   = drop_ff + 1'b1;
                  result_in = '{status: ST_FULL, index: NONE_INDEX};
               end
            end else begin
               key_wr_en   = 1'b1;
               rec_wr_en   = 1'b1;
               rec_wr_addr = fill_ff[IDX_W-1:0];
               rec_wr_data = '{best_strength: strength_ff, first_sweep: sweep_ff,
                               latest_sweep: sweep_ff, seen_count: COUNT_W'(1)};
               fill_in     = fill_ff + 1'b1;
               result_in   = '{status: ST_INSERTED, index: INDEX_W'(fill_ff)};
            end
         end
         S_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         drop_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      result_ff  <= result_in;
      if (accept) begin
         addr_ff     <= req_station_address;
         strength_ff <= req_strength;
         sweep_ff    <= req_sweep_number;
      end
   end

endmodule
